>>> hw/rtl/ordered_list_insert_front_delete_match_macros.svh
// assertion macros for the ordered list block
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ORDERED_LIST_INSERT_FRONT_DELETE_MATCH_MACROS_SVH
`define ORDERED_LIST_INSERT_FRONT_DELETE_MATCH_MACROS_SVH

// condition holds at every edge outside reset
`define OLM_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define OLM_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OLM_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/olist_pkg.sv
// shared constants for the ordered list block: field widths, opcodes, status codes
// no dependencies
package olist_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int DATA_W       = 32;
	localparam int OP_W         = 2;
	localparam int STAT_W       = 3;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] STAT_DELETED   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_ELEMENT   = 3'd4;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd5;

endpackage

>>> hw/rtl/ordered_list_insert_front_delete_match.sv
// ordered list: insert, or delete/readout of an empty list, result the cycle after accept
// delete scans entries from the front (S_SRCH), moves those above the match down (S_SHIFT)
// readout: front to back, one beat per cycle while the output is not stalled
// one request at a time; the list memory has one read port and one write port
// reset clears count, state and output valid; list memory is not cleared
// depends on olist_pkg and ordered_list_insert_front_delete_match_macros.svh
`include "ordered_list_insert_front_delete_match_macros.svh"

module ordered_list_insert_front_delete_match #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [olist_pkg::DATA_W-1:0]     s_axis_tdata,   // value
	input  logic [olist_pkg::OP_W-1:0]       s_axis_tuser,   // op
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [olist_pkg::DATA_W-1:0]     m_axis_tdata,   // entry
	output logic [olist_pkg::STAT_W-1:0]     m_axis_tuser,   // status
	output logic                             m_axis_tlast
);
	import olist_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [2:0] {S_IDLE, S_SRCH, S_SHIFT, S_RESP, S_READ} state_t;

	// memory index 0 is the back of the list, count-1 the front
	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rd_data_q;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     ptr_q;
	logic [DATA_W-1:0] val_q;
	logic [STAT_W-1:0] st_q;
	logic              m_valid_q;
	logic [DATA_W-1:0] m_entry_q;
	logic [STAT_W-1:0] m_stat_q;
	logic              m_last_q;

	logic              out_free;
	logic              in_acc;
	logic              out_load;
	logic [AW-1:0]     front;
	logic              last_move;
	logic              hit;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign front         = AW'(cnt_q - 1'b1);
	assign last_move     = (AW'(ptr_q + 1'b1) == front);
	assign hit           = (rd_data_q == val_q);

	// a result beat is loaded into the output register this cycle
	assign out_load = ((state_q == S_IDLE) && in_acc &&
	                   ((s_axis_tuser == OP_INSERT) ||
	                    ((cnt_q == '0) &&
	                     (s_axis_tuser == OP_DELETE || s_axis_tuser == OP_READ)))) ||
	                  (((state_q == S_RESP) || (state_q == S_READ)) && out_free);

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_entry_q;
	assign m_axis_tuser  = m_stat_q;
	assign m_axis_tlast  = m_last_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = front;
		wr_en   = 1'b0;
		wr_addr = AW'(cnt_q);
		wr_data = s_axis_tdata;
		case (state_q)
			S_IDLE: begin
				if (in_acc && cnt_q != '0 &&
				    (s_axis_tuser == OP_DELETE || s_axis_tuser == OP_READ)) begin
					rd_en = 1'b1;
				end
				if (in_acc && s_axis_tuser == OP_INSERT && cnt_q != CAP_C) begin
					wr_en = 1'b1;
				end
			end
			S_SRCH: begin
				if (!hit && ptr_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q - 1'b1;
				end else if (hit && ptr_q != front) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + 1'b1;
				end
			end
			S_SHIFT: begin
				// close the gap: entry ptr+1 moves down to ptr, fetch the one after
				wr_en   = 1'b1;
				wr_addr = ptr_q;
				wr_data = rd_data_q;
				if (!last_move) begin
					rd_en   = 1'b1;
					rd_addr = AW'(ptr_q + 2'd2);
				end
			end
			S_READ: begin
				if (out_free && ptr_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			ptr_q     <= '0;
			val_q     <= '0;
			st_q      <= STAT_INSERTED;
			m_valid_q <= 1'b0;
			m_entry_q <= '0;
			m_stat_q  <= STAT_INSERTED;
			m_last_q  <= 1'b0;
		end else begin
			m_valid_q <= out_load || (m_valid_q && !m_axis_tready);
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						val_q <= s_axis_tdata;
						case (s_axis_tuser)
							OP_INSERT: begin
								m_entry_q <= s_axis_tdata;
								m_last_q  <= 1'b1;
								if (cnt_q == CAP_C) begin
									m_stat_q <= STAT_FULL;
								end else begin
									m_stat_q <= STAT_INSERTED;
									cnt_q    <= cnt_q + 1'b1;
								end
							end
							OP_DELETE: begin
								if (cnt_q == '0) begin
									m_entry_q <= s_axis_tdata;
									m_stat_q  <= STAT_NOT_FOUND;
									m_last_q  <= 1'b1;
								end else begin
									ptr_q   <= front;
									state_q <= S_SRCH;
								end
							end
							OP_READ: begin
								if (cnt_q == '0) begin
									m_entry_q <= '0;
									m_stat_q  <= STAT_EMPTY;
									m_last_q  <= 1'b1;
								end else begin
									ptr_q   <= front;
									state_q <= S_READ;
								end
							end
							default: ;
						endcase
					end
				end
				S_SRCH: begin
					if (hit) begin
						if (ptr_q == front) begin
							cnt_q   <= cnt_q - 1'b1;
							st_q    <= STAT_DELETED;
							state_q <= S_RESP;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (ptr_q == '0) begin
						st_q    <= STAT_NOT_FOUND;
						state_q <= S_RESP;
					end else begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
				S_SHIFT: begin
					if (last_move) begin
						cnt_q   <= cnt_q - 1'b1;
						st_q    <= STAT_DELETED;
						state_q <= S_RESP;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_RESP: begin
					if (out_free) begin
						m_entry_q <= val_q;
						m_stat_q  <= st_q;
						m_last_q  <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_READ: begin
					if (out_free) begin
						m_entry_q <= rd_data_q;
						m_stat_q  <= STAT_ELEMENT;
						m_last_q  <= (ptr_q == '0);
						if (ptr_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= ptr_q - 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`OLM_ASSERT(a_cnt_bound, cnt_q <= CAP_C, "list count above capacity")
	`OLM_NEXT(a_ins_grow, in_acc && s_axis_tuser == OP_INSERT && cnt_q != CAP_C,
		cnt_q == $past(cnt_q) + 1'b1, "insert did not grow the list")
	`OLM_IMPLY(a_shift_range, state_q == S_SHIFT, (CW'(ptr_q) + 1'b1) < cnt_q,
		"compaction ran past the front")
	`OLM_IMPLY(a_single_last, m_valid_q && m_stat_q != STAT_ELEMENT, m_last_q,
		"single result beat without last")

endmodule
